>>> rtl/spk_pkg.sv
// Shared constants, types and helpers for the stochastic %K block.
package spk_pkg;

   localparam int WINDOW_MAX   = 16;
   localparam int WINDOW_MIN   = 2;
   localparam int WINDOW_RESET = 14;
   localparam int PRICE_BITS   = 32;
   localparam int CFG_BITS     = 5;
   localparam int K_BITS       = 14;
   localparam int K_SCALE_VAL  = 10000;

   localparam int SLOT_BITS  = $clog2(WINDOW_MAX);
   localparam int COUNT_BITS = $clog2(WINDOW_MAX + 1);
   localparam int PROD_BITS  = PRICE_BITS + K_BITS;
   localparam int STEP_BITS  = $clog2(K_BITS);

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic [CFG_BITS-1:0]   cfg_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [K_BITS-1:0]     k_type;
   typedef logic [PROD_BITS-1:0]  prod_type;
   typedef logic [STEP_BITS-1:0]  step_type;

   localparam k_type K_SCALE = k_type'(K_SCALE_VAL);

   // scan unit -> control
   typedef struct packed {
      logic done;
      logic window_full;
   } scan_status_type;

   // register value -> window length actually used
   function automatic count_type clamp_window(cfg_type w);
      int v;
      v = int'(w);
      if (v < WINDOW_MIN) v = WINDOW_MIN;
      if (v > WINDOW_MAX) v = WINDOW_MAX;
      return count_type'(v);
   endfunction

endpackage

>>> rtl/spk_if.sv
// Request and response channel interfaces of the stochastic %K block.
interface spk_req_if import spk_pkg::*; ();
   logic      valid;
   logic      ready;
   price_type day_high;
   price_type day_low;
   price_type day_close;

   modport source (output valid, output day_high, output day_low, output day_close,
                   input ready);
   modport sink   (input valid, input day_high, input day_low, input day_close,
                   output ready);
endinterface

interface spk_rsp_if import spk_pkg::*; ();
   logic  valid;
   logic  ready;
   k_type percent_k;
   logic  result_valid;

   modport source (output valid, output percent_k, output result_valid, input ready);
   modport sink   (input valid, input percent_k, input result_valid, output ready);
endinterface

>>> rtl/stochastic_percent_k.sv
// Stochastic %K top level: request/response channels, window register, control.
// Flow: on accept the day is written to the ring. While the window is still filling
//   the scan ends at once and no division runs; with a full window of N days (N = 2..16)
//   the scan reads the older entries, then H <= L or a close at or outside L..H ends at once
//   and otherwise the division runs. Throughput: one request at a time; each request takes
//   the window scan (one ring read a cycle), plus 14 multiply and 14 divide steps if needed.
// Reset is synchronous: history count, ring pointer and window length (14) reset.
module stochastic_percent_k import spk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   spk_req_if.sink     req_chan,
   spk_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  cfg_type     csr_write_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CALC, ST_HOLD} top_state_type;

   top_state_type state_ff;
   cfg_type       window_ff;
   price_type     close_ff;
   logic          rsp_valid_ff;
   k_type         rsp_k_ff;
   logic          rsp_rv_ff;

   logic            req_accept;
   logic            rsp_free;
   count_type       window_days;
   scan_status_type scan_status;
   price_type       scan_top;
   price_type       scan_bottom;
   logic            kdiv_done;
   k_type           kdiv_k;
   logic            kdiv_rv;

   // one request in flight; the output register lets the next one in
   // while a response still waits downstream
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign window_days    = clamp_window(window_ff);

   // window length register; write it only while idle, the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= cfg_type'(WINDOW_RESET);
      end else if (csr_write_enable) begin
         window_ff <= csr_write_data;
      end
   end

   // ring write plus scan of the newest N entries
   spk_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .day_high    (req_chan.day_high),
      .day_low     (req_chan.day_low),
      .window_days (window_days),
      .status      (scan_status),
      .top         (scan_top),
      .bottom      (scan_bottom)
   );

   // saturation checks, then serial (close - L) * 10000 / (H - L)
   spk_kdiv u_kdiv (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_status.done),
      .window_full  (scan_status.window_full),
      .day_close    (close_ff),
      .top          (scan_top),
      .bottom       (scan_bottom),
      .done         (kdiv_done),
      .percent_k    (kdiv_k),
      .result_valid (kdiv_rv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  close_ff <= req_chan.day_close;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_status.done) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC, ST_HOLD: begin
               // kdiv holds its result until the next start
               if ((state_ff == ST_HOLD) || kdiv_done) begin
                  if (rsp_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_k_ff     <= kdiv_k;
                     rsp_rv_ff    <= kdiv_rv;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.percent_k    = rsp_k_ff;
   assign rsp_chan.result_valid = rsp_rv_ff;

endmodule

>>> rtl/spk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/spk_scan.sv
// Price ring and window scan for highest high and lowest low.
module spk_scan import spk_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  price_type       day_high,
   input  price_type       day_low,
   input  count_type       window_days,
   output scan_status_type status,
   output price_type       top,
   output price_type       bottom
);

   typedef enum logic [1:0] {SC_IDLE, SC_READ, SC_LAST} scan_state_type;

   localparam slot_type SLOT_LAST = slot_type'(WINDOW_MAX - 1);
   localparam count_type DAYS_FULL = count_type'(WINDOW_MAX);

   scan_state_type state_ff;
   slot_type       slot_ff;
   slot_type       rd_addr_ff;
   count_type      days_ff;
   count_type      remain_ff;
   logic           pend_ff;
   logic           done_ff;
   logic           full_ff;
   price_type      top_ff;
   price_type      bottom_ff;

   logic [2*PRICE_BITS-1:0] ring_rd;
   price_type ring_high;
   price_type ring_low;
   slot_type  slot_in;
   slot_type  slot_back;
   slot_type  rd_addr_in;
   count_type days_in;
   price_type top_in;
   price_type bottom_in;

   spk_ram #(
      .WIDTH (2 * PRICE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (start),
      .wr_addr (slot_ff),
      .wr_data ({day_high, day_low}),
      .rd_en   (state_ff == SC_READ),
      .rd_addr (rd_addr_ff),
      .rd_data (ring_rd)
   );

   assign ring_high = ring_rd[2*PRICE_BITS-1:PRICE_BITS];
   assign ring_low  = ring_rd[PRICE_BITS-1:0];

   assign slot_in    = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
   assign slot_back  = (slot_ff == '0) ? SLOT_LAST : slot_ff - 1'b1;
   assign rd_addr_in = (rd_addr_ff == '0) ? SLOT_LAST : rd_addr_ff - 1'b1;
   assign days_in    = (days_ff == DAYS_FULL) ? days_ff : days_ff + 1'b1;

   // fold the entry read last cycle
   assign top_in    = (pend_ff && (ring_high > top_ff)) ? ring_high : top_ff;
   assign bottom_in = (pend_ff && (ring_low < bottom_ff)) ? ring_low : bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         slot_ff  <= '0;
         days_ff  <= '0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         done_ff   <= 1'b0;
         pend_ff   <= (state_ff == SC_READ);
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         case (state_ff)
            SC_IDLE: begin
               if (start) begin
                  slot_ff    <= slot_in;
                  days_ff    <= days_in;
                  top_ff     <= day_high;
                  bottom_ff  <= day_low;
                  rd_addr_ff <= slot_back;
                  remain_ff  <= window_days - count_type'(1);
                  if (days_in >= window_days) begin
                     full_ff  <= 1'b1;
                     state_ff <= SC_READ;
                  end else begin
                     full_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
            SC_READ: begin
               rd_addr_ff <= rd_addr_in;
               remain_ff  <= remain_ff - count_type'(1);
               if (remain_ff == count_type'(1)) begin
                  state_ff <= SC_LAST;
               end
            end
            SC_LAST: begin
               done_ff  <= 1'b1;
               state_ff <= SC_IDLE;
            end
            default: begin
               state_ff <= SC_IDLE;
            end
         endcase
      end
   end

   assign status.done        = done_ff;
   assign status.window_full = full_ff;
   assign top                = top_ff;
   assign bottom             = bottom_ff;

endmodule

>>> rtl/spk_kdiv.sv
// Bit-serial scaling multiply and restoring division giving %K.
module spk_kdiv import spk_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      window_full,
   input  price_type day_close,
   input  price_type top,
   input  price_type bottom,
   output logic      done,
   output k_type     percent_k,
   output logic      result_valid
);

   typedef enum logic [1:0] {KD_IDLE, KD_MUL, KD_DIV} kdiv_state_type;

   kdiv_state_type state_ff;
   prod_type       prod_ff;
   price_type      diff_ff;
   price_type      range_ff;
   k_type          mplr_ff;
   step_type       step_ff;
   logic           done_ff;
   k_type          k_ff;
   logic           valid_ff;

   prod_type                mul_in;
   logic [PRICE_BITS:0]     trial;
   logic [PRICE_BITS:0]     trial_sub;
   logic                    q_bit;
   price_type               rem_in;

   // multiply: MSB first, one multiplier bit a cycle
   assign mul_in = {prod_ff[PROD_BITS-2:0], 1'b0}
                 + (mplr_ff[K_BITS-1] ? {{K_BITS{1'b0}}, diff_ff} : '0);

   // divide: {remainder, dividend bits} shift left, quotient bits enter at the bottom
   assign trial     = prod_ff[PROD_BITS-1:K_BITS-1];
   assign trial_sub = trial - {1'b0, range_ff};
   assign q_bit     = (trial >= {1'b0, range_ff});
   assign rem_in    = q_bit ? trial_sub[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            KD_IDLE: begin
               if (start) begin
                  diff_ff  <= day_close - bottom;
                  range_ff <= top - bottom;
                  if (!window_full || (top <= bottom)) begin
                     k_ff     <= '0;
                     valid_ff <= 1'b0;
                     done_ff  <= 1'b1;
                  end else if (day_close <= bottom) begin
                     k_ff     <= '0;
                     valid_ff <= 1'b1;
                     done_ff  <= 1'b1;
                  end else if (day_close >= top) begin
                     k_ff     <= K_SCALE;
                     valid_ff <= 1'b1;
                     done_ff  <= 1'b1;
                  end else begin
                     prod_ff  <= '0;
                     mplr_ff  <= K_SCALE;
                     step_ff  <= step_type'(K_BITS - 1);
                     state_ff <= KD_MUL;
                  end
               end
            end
            KD_MUL: begin
               prod_ff <= mul_in;
               mplr_ff <= {mplr_ff[K_BITS-2:0], 1'b0};
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  step_ff  <= step_type'(K_BITS - 1);
                  state_ff <= KD_DIV;
               end
            end
            KD_DIV: begin
               prod_ff <= {rem_in, prod_ff[K_BITS-2:0], q_bit};
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  k_ff     <= {prod_ff[K_BITS-2:0], q_bit};
                  valid_ff <= 1'b1;
                  done_ff  <= 1'b1;
                  state_ff <= KD_IDLE;
               end
            end
            default: begin
               state_ff <= KD_IDLE;
            end
         endcase
      end
   end

   assign done         = done_ff;
   assign percent_k    = k_ff;
   assign result_valid = valid_ff;

endmodule

>>> rtl/spk_checker.sv
// Port-level checks for the stochastic %K block, bound to the top level.
module spk_checker import spk_pkg::*; (
   input logic  clock,
   input logic  reset,
   input logic  req_valid,
   input logic  req_ready,
   input logic  rsp_valid,
   input logic  rsp_ready,
   input k_type percent_k,
   input logic  result_valid
);

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(percent_k) && $stable(result_valid))
      else $error("stalled response changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_valid |-> percent_k <= K_SCALE)
      else $error("percent_k above full scale");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !result_valid |-> percent_k == '0)
      else $error("invalid response with nonzero percent_k");

endmodule

bind stochastic_percent_k spk_checker u_spk_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .percent_k    (rsp_chan.percent_k),
   .result_valid (rsp_chan.result_valid)
);

>>> bench/tb_top.sv
// Self-checking testbench for the stochastic %K block: directed table, random days, checker.
`timescale 1ns / 100ps

module tb_top;
   import spk_pkg::*;

   // Generous cycle ceiling. Slowest correct run is about 1050 requests, each with
   // the block's own processing, a random sender gap and receiver stalls, plus one
   // long receiver hold and the drains between phases.
   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_SETTLE  = 4;      // idle cycles before a register write
   localparam int END_SETTLE    = 60;     // wait after the last response before the verdict
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_DAYS    = 103;
   localparam int HOLD_AFTER    = 300;    // responses seen before the long hold
   localparam int HOLD_CYCLES   = 600;

   localparam price_type PRICE_TOP = '1;
   localparam price_type PRICE_MID = 32'h7FFF_FFFF;
   localparam price_type PRICE_HALF = 32'h8000_0000;

   // One expected response.
   typedef struct packed {
      k_type percent_k;
      logic  result_valid;
   } k_result_type;

   // One directed request. Where "pinned" is set, the response is typed in here;
   // otherwise it comes from the predictor.
   typedef struct packed {
      cfg_type   window;
      price_type high;
      price_type low;
      price_type close;
      logic      pinned;
      k_type     percent_k;
      logic      result_valid;
   } day_row_type;

   localparam int DIRECTED_DAYS = 22;

   // window 0 and 1 act as 2, 17 and 31 act as 16
   day_row_type day_table [DIRECTED_DAYS] = '{
      // window still filling right after reset (window 14)
      '{5'd14, 32'd100, 32'd50, 32'd75, 1'b1, 14'd0, 1'b0},
      '{5'd14, 32'd0, 32'd0, 32'd0, 1'b1, 14'd0, 1'b0},
      // full price range, close at each end, then a mid-range close
      '{5'd0, PRICE_TOP, 32'd0, PRICE_TOP, 1'b1, 14'd10000, 1'b1},
      '{5'd0, PRICE_TOP, 32'd0, 32'd0, 1'b1, 14'd0, 1'b1},
      '{5'd0, 32'd1000, 32'd0, 32'd500, 1'b0, 14'd0, 1'b0},
      '{5'd0, 32'd1000, 32'd0, 32'd500, 1'b1, 14'd5000, 1'b1},
      // close inside the range, then below the lowest low, then above the highest high
      '{5'd0, 32'd1000, 32'd500, 32'd10, 1'b1, 14'd100, 1'b1},
      '{5'd0, 32'd1000, 32'd500, 32'd10, 1'b1, 14'd0, 1'b1},
      '{5'd0, 32'd1000, 32'd500, 32'd5000, 1'b1, 14'd10000, 1'b1},
      // close at the low, flat range, inverted range, then wide ranges with closes between
      '{5'd0, 32'd5, 32'd5, 32'd5, 1'b1, 14'd0, 1'b1},
      '{5'd0, 32'd5, 32'd5, 32'd5, 1'b1, 14'd0, 1'b0},
      '{5'd0, 32'd3, 32'd9, 32'd6, 1'b1, 14'd0, 1'b0},
      '{5'd0, 32'd3, 32'd9, 32'd6, 1'b1, 14'd0, 1'b0},
      '{5'd0, PRICE_TOP, 32'd0, PRICE_MID, 1'b0, 14'd0, 1'b0},
      '{5'd1, PRICE_TOP, 32'd0, PRICE_MID, 1'b0, 14'd0, 1'b0},
      '{5'd1, 32'hAAAA_AAAA, 32'h5555_5555, PRICE_HALF, 1'b0, 14'd0, 1'b0},
      // wide windows, history kept across the length change
      '{5'd31, 32'd200, 32'd100, 32'd150, 1'b0, 14'd0, 1'b0},
      '{5'd31, 32'd0, 32'd0, 32'd0, 1'b0, 14'd0, 1'b0},
      '{5'd16, 32'h1234_5678, 32'h09AB_CDEF, 32'h0FED_CBA9, 1'b0, 14'd0, 1'b0},
      '{5'd17, PRICE_HALF, PRICE_MID, PRICE_HALF, 1'b0, 14'd0, 1'b0},
      // back to the narrowest window: one-tick range
      '{5'd2, PRICE_HALF, PRICE_MID, PRICE_HALF, 1'b1, 14'd10000, 1'b1},
      '{5'd2, PRICE_HALF, PRICE_MID, PRICE_MID, 1'b1, 14'd0, 1'b1}
   };

   cfg_type phase_windows [RANDOM_PHASES] = '{
      5'd2, 5'd16, 5'd0, 5'd31, 5'd7, 5'd1, 5'd17, 5'd14, 5'd3, 5'd11
   };

   logic    clock;
   logic    reset;
   logic    csr_write_enable;
   cfg_type csr_write_data;

   spk_req_if req_bus ();
   spk_rsp_if rsp_bus ();

   stochastic_percent_k u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus.sink),
      .rsp_chan         (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: price history, fill count and the window register copy.
   // ---------------------------------------------------------------------------
   price_type high_hist [WINDOW_MAX];
   price_type low_hist  [WINDOW_MAX];
   int        hist_slot   = 0;
   int        days_filled = 0;
   cfg_type   window_reg  = cfg_type'(WINDOW_RESET);

   k_result_type pending_k [$];   // responses still owed, oldest first

   int mismatches     = 0;
   int responses_seen = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   logic [31:0] price_level = 32'd0;

   // Receiver stall pattern state
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   logic [11:0] rx_cycle  = '0;

   // Writes the day into the history and returns %K over the current window.
   function automatic k_result_type predict_percent_k(price_type hi, price_type lo,
                                                      price_type cl);
      int           span;
      int           idx;
      price_type    top;
      price_type    bottom;
      logic [63:0]  scaled;
      k_result_type res;

      span = int'(window_reg);
      if (span < 2) span = 2;
      if (span > WINDOW_MAX) span = WINDOW_MAX;

      high_hist[hist_slot] = hi;
      low_hist[hist_slot]  = lo;
      hist_slot = (hist_slot + 1) % WINDOW_MAX;
      if (days_filled < WINDOW_MAX) days_filled++;

      res = '0;
      if (days_filled >= span) begin
         top    = '0;
         bottom = '1;
         for (int i = 0; i < span; i++) begin
            idx = (hist_slot + WINDOW_MAX - 1 - i) % WINDOW_MAX;
            if (high_hist[idx] > top) top = high_hist[idx];
            if (low_hist[idx] < bottom) bottom = low_hist[idx];
         end
         if (top > bottom) begin
            res.result_valid = 1'b1;
            if (cl <= bottom) begin
               res.percent_k = '0;
            end else if (cl >= top) begin
               res.percent_k = k_type'(K_SCALE_VAL);
            end else begin
               scaled = (64'(cl) - 64'(bottom)) * 64'(K_SCALE_VAL) / (64'(top) - 64'(bottom));
               res.percent_k = k_type'(scaled);
            end
         end
      end
      return res;
   endfunction

   // Presents one request, holds it until accepted, then books the response.
   task automatic offer_day(input price_type hi, input price_type lo, input price_type cl,
                            input logic pinned, input k_type k, input logic ok);
      k_result_type want;
      req_bus.valid     <= 1'b1;
      req_bus.day_high  <= hi;
      req_bus.day_low   <= lo;
      req_bus.day_close <= cl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = predict_percent_k(hi, lo, cl);
      if (pinned) begin
         want.percent_k    = k;
         want.result_valid = ok;
      end
      pending_k = {pending_k, want};
   endtask

   // Sender pacing: bursts of back-to-back requests separated by random gaps.
   task automatic pace_sender();
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // mostly short bursts, now and then a long unbroken run
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   // Stops sending, waits for every owed response, then writes the window length.
   task automatic write_window(input cfg_type w);
      req_bus.valid <= 1'b0;
      while (pending_k.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_reg = w;
   endtask

   // Random day. Most days are well formed around a drifting price level
   // (low <= close <= high); the rest are noise, flat days and extremes.
   task automatic make_day(output price_type hi, output price_type lo, output price_type cl);
      logic [63:0] up;
      logic [63:0] dn;
      logic [63:0] h64;
      logic [63:0] l64;
      logic [63:0] drift;
      int          kind;

      kind = $urandom_range(0, 99);
      drift = 64'($urandom >> $urandom_range(6, 31));
      if ($urandom_range(0, 1) == 1) begin
         h64 = 64'(price_level) + drift;
         price_level = (h64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : h64[31:0];
      end else begin
         price_level = (drift > 64'(price_level)) ? 32'd0 : price_level - drift[31:0];
      end

      if (kind < 72) begin
         up  = 64'($urandom >> $urandom_range(0, 31));
         dn  = 64'($urandom >> $urandom_range(0, 31));
         h64 = 64'(price_level) + up;
         if (h64 > 64'hFFFF_FFFF) h64 = 64'hFFFF_FFFF;
         l64 = (dn > 64'(price_level)) ? 64'd0 : 64'(price_level) - dn;
         hi = h64[31:0];
         lo = l64[31:0];
         cl = price_type'(l64 + ({$urandom, $urandom} % (h64 - l64 + 64'd1)));
      end else if (kind < 85) begin
         hi = $urandom;
         lo = $urandom;
         cl = $urandom;
      end else if (kind < 93) begin
         hi = price_level;
         lo = price_level;
         cl = ($urandom_range(0, 1) == 1) ? price_level : price_type'($urandom);
      end else begin
         hi = ($urandom_range(0, 1) == 1) ? PRICE_TOP : price_level;
         lo = ($urandom_range(0, 1) == 1) ? price_type'(0) : price_level;
         case ($urandom_range(0, 3))
            0: cl = '0;
            1: cl = PRICE_TOP;
            2: cl = lo;
            default: cl = hi;
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------
   // Clock, known input values at time zero, cycle ceiling.
   // ---------------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.day_high  = '0;
      req_bus.day_low   = '0;
      req_bus.day_close = '0;
      rsp_bus.ready     = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: its own stall pattern, cycling through four moods in turn,
   // plus one long hold once traffic is flowing so the block backs up
   // and drops request ready while the sender keeps offering.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (!hold_done && responses_seen >= HOLD_AFTER) begin
         rsp_bus.ready <= 1'b0;
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end else begin
         rx_cycle = rx_cycle + 1'b1;
         case (rx_cycle[9:8])
            2'd0: rsp_bus.ready <= 1'b1;                              // no stalls
            2'd1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);       // coin flip
            2'd2: rsp_bus.ready <= ($urandom_range(0, 9) != 0);       // rare stall
            default: rsp_bus.ready <= (rx_cycle[3:0] > 4'd4);         // periodic stall runs
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Checker: every accepted response against the oldest owed one.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      k_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_seen++;
         if (pending_k.size() == 0) begin
            $error("response with none owed: percent_k=%0d result_valid=%0b",
                   rsp_bus.percent_k, rsp_bus.result_valid);
            mismatches++;
         end else begin
            want = pending_k.pop_front();
            if (rsp_bus.percent_k !== want.percent_k) begin
               $error("percent_k: expected %0d, got %0d", want.percent_k, rsp_bus.percent_k);
               mismatches++;
            end
            if (rsp_bus.result_valid !== want.result_valid) begin
               $error("result_valid: expected %0b, got %0b",
                      want.result_valid, rsp_bus.result_valid);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus: reset, directed table, then random phases with a fresh window
   // length each (the sender drains before every write), then final verdict.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      price_type hi;
      price_type lo;
      price_type cl;
      cfg_type   w;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table. A row whose window differs from the register drains
      // first, so the first rows run at the reset length of 14.
      foreach (day_table[r]) begin
         if (day_table[r].window != window_reg) write_window(day_table[r].window);
         offer_day(day_table[r].high, day_table[r].low, day_table[r].close,
                   day_table[r].pinned, day_table[r].percent_k, day_table[r].result_valid);
         pace_sender();
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         w = phase_windows[ph];
         if (ph == 4 || ph == 8) w = cfg_type'($urandom_range(0, 31));
         write_window(w);
         price_level = $urandom;
         for (int d = 0; d < PHASE_DAYS; d++) begin
            make_day(hi, lo, cl);
            offer_day(hi, lo, cl, 1'b0, '0, 1'b0);
            pace_sender();
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_k.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> stochastic_percent_k.f
rtl/spk_pkg.sv
rtl/spk_if.sv
rtl/spk_ram.sv
rtl/spk_scan.sv
rtl/spk_kdiv.sv
rtl/stochastic_percent_k.sv
rtl/spk_checker.sv
bench/tb_top.sv
